// ----- design/enr_pkg.sv -----
// ----------------------------------------------------------------------------
// enr_pkg
// Types and class codes shared by the Euler number bit-quad blocks, and the
// window classifier used by the accumulator.
// ----------------------------------------------------------------------------
package enr_pkg;

  localparam int unsigned RESULT_BITS = 16;
  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned WIDTH_REG_BITS = 9;
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET = 9'd16;
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_MIN = 9'd2;

  typedef struct packed {
    logic pixel_black;
    logic last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic        [RESULT_BITS-1:0] count_empty;
    logic        [RESULT_BITS-1:0] count_one;
    logic        [RESULT_BITS-1:0] count_two_adjacent;
    logic        [RESULT_BITS-1:0] count_three;
    logic        [RESULT_BITS-1:0] count_full;
    logic        [RESULT_BITS-1:0] count_diagonal;
    logic signed [RESULT_BITS-1:0] euler_number;
  } result_t;

  typedef enum logic [2:0] {
    QUAD_EMPTY    = 3'd0,
    QUAD_ONE      = 3'd1,
    QUAD_TWO_ADJ  = 3'd2,
    QUAD_THREE    = 3'd3,
    QUAD_FULL     = 3'd4,
    QUAD_DIAGONAL = 3'd5
  } quad_class_t;

  // per-pixel control carried from the input register to the accumulator
  typedef struct packed {
    logic cur;
    logic last;
    logic window_en;
    logic first_row;
  } pixel_ctrl_t;

  function automatic quad_class_t classify_quad(input logic a, input logic b,
                                                input logic c, input logic d);
    quad_class_t cls;
    logic [2:0]  n;
    n = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    case (n)
      3'd0:    cls = QUAD_EMPTY;
      3'd1:    cls = QUAD_ONE;
      3'd2:    cls = ((a && d) || (b && c)) ? QUAD_DIAGONAL : QUAD_TWO_ADJ;
      3'd3:    cls = QUAD_THREE;
      default: cls = QUAD_FULL;
    endcase
    return cls;
  endfunction

endpackage

// ----- design/enr_ram.sv -----
// ----------------------------------------------------------------------------
// enr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module enr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/enr_quad_accum.sv -----
// ----------------------------------------------------------------------------
// enr_quad_accum
// Window classification, saturating class counters, Euler number and the
// result register.
// ----------------------------------------------------------------------------
module enr_quad_accum
  import enr_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  pixel_ctrl_t ctrl,
  input  logic        upper_raw,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_stall
);

  localparam int unsigned NW = COUNT_BITS + 3;
  localparam int unsigned QW = (NW > RESULT_BITS) ? NW : RESULT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [QW-1:0] EULER_MAX = QW'($signed(32'sd32767));
  localparam logic signed [QW-1:0] EULER_MIN = QW'($signed(-32'sd32768));

  logic [COUNT_BITS-1:0] counters      [NUM_CLASSES];
  logic [COUNT_BITS-1:0] counters_next [NUM_CLASSES];
  logic                  left_pixel;
  logic                  upper_left_pixel;
  logic                  upper;
  quad_class_t           cls;
  logic                  result_valid_next;
  logic signed [NW-1:0]  num;
  logic signed [QW-1:0]  num_ext;
  logic signed [QW-1:0]  quot;
  logic signed [QW-1:0]  euler_sat;

  assign upper = ctrl.first_row ? 1'b0 : upper_raw;
  assign cls   = classify_quad(upper_left_pixel, upper, left_pixel, ctrl.cur);

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      counters_next[k] = counters[k];
      if (ctrl.window_en && (cls == quad_class_t'(k)) && (counters[k] != COUNT_MAX)) begin
        counters_next[k] = counters[k] + COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    num = $signed({3'b000, counters_next[QUAD_ONE]})
        - $signed({3'b000, counters_next[QUAD_THREE]})
        - $signed({2'b00, counters_next[QUAD_DIAGONAL], 1'b0});
    num_ext = QW'(num);
    // round toward zero
    if (num_ext < 0) begin
      quot = (num_ext + QW'(3)) >>> 2;
    end else begin
      quot = num_ext >>> 2;
    end
    if (quot > EULER_MAX) begin
      euler_sat = EULER_MAX;
    end else if (quot < EULER_MIN) begin
      euler_sat = EULER_MIN;
    end else begin
      euler_sat = quot;
    end
  end

  assign result_valid_next = (result_valid && result_stall) || (advance && ctrl.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid     <= 1'b0;
      left_pixel       <= 1'b0;
      upper_left_pixel <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        counters[k] <= '0;
      end
    end else begin
      result_valid <= result_valid_next;
      if (advance) begin
        if (ctrl.last) begin
          left_pixel       <= 1'b0;
          upper_left_pixel <= 1'b0;
          for (int k = 0; k < NUM_CLASSES; k++) begin
            counters[k] <= '0;
          end
        end else begin
          left_pixel       <= ctrl.cur;
          upper_left_pixel <= upper;
          for (int k = 0; k < NUM_CLASSES; k++) begin
            counters[k] <= counters_next[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl.last) begin
      result.count_empty        <= RESULT_BITS'(counters_next[QUAD_EMPTY]);
      result.count_one          <= RESULT_BITS'(counters_next[QUAD_ONE]);
      result.count_two_adjacent <= RESULT_BITS'(counters_next[QUAD_TWO_ADJ]);
      result.count_three        <= RESULT_BITS'(counters_next[QUAD_THREE]);
      result.count_full         <= RESULT_BITS'(counters_next[QUAD_FULL]);
      result.count_diagonal     <= RESULT_BITS'(counters_next[QUAD_DIAGONAL]);
      result.euler_number       <= RESULT_BITS'(euler_sat);
    end
  end

endmodule

// ----- design/euler_number_bit_quads_core.sv -----
// ----------------------------------------------------------------------------
// euler_number_bit_quads_core
// 8-connected Euler number of a padded binary blob by bit-quad counting.
// ----------------------------------------------------------------------------
// Pixels of the padded bounding box enter in raster order, one per clock
// when neither side stalls; the last pixel passes the input register s1,
// then the result register. A one-row line buffer RAM (read and written
// once per pixel) forms each 2x2 window, classified from s1 and counted as
// the accumulator advances. A pixel flagged last_pixel produces one result
// transaction with the six saturating class counts and the Euler number, and
// clears the blob state; other pixels produce none. line_width (padded row
// length, clamped to 2..MAX_LINE) is set by cfg_write_en/cfg_write_data;
// the user must write it between blobs only; the block does not enforce it.
module euler_number_bit_quads_core
  import enr_pkg::*;
#(
  parameter int unsigned MAX_LINE   = 256,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [WIDTH_REG_BITS-1:0] cfg_write_data,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  pixel_in_t                 pixel,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result
);

  localparam int unsigned CW = $clog2(MAX_LINE);
  localparam int unsigned WW = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_LINE);

  logic [WIDTH_REG_BITS-1:0] line_width;
  logic [CW-1:0]             column_index;
  logic                      in_first_row;
  logic [WW-1:0]             lw_ext;
  logic [WW-1:0]             width_eff;
  logic [CW-1:0]             col;
  logic [WW-1:0]             col_inc;
  logic                      accept;
  logic                      advance;
  logic                      s1_valid;
  pixel_ctrl_t               s1_ctrl;
  logic                      upper_raw;

  assign lw_ext = WW'(line_width);

  always_comb begin
    if (lw_ext < WW'(WIDTH_MIN)) begin
      width_eff = WW'(WIDTH_MIN);
    end else if (lw_ext > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = lw_ext;
    end
    col     = (WW'(column_index) >= width_eff) ? '0 : column_index;
    col_inc = WW'(col) + WW'(1);
  end

  assign advance     = s1_valid && !(s1_ctrl.last && result_valid && result_stall);
  assign pixel_stall = s1_valid && !advance;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= WIDTH_RESET;
      column_index <= '0;
      in_first_row <= 1'b1;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        line_width <= cfg_write_data;
      end
      s1_valid <= accept || pixel_stall;
      if (accept) begin
        if (pixel.last_pixel) begin
          column_index <= '0;
          in_first_row <= 1'b1;
        end else if (col_inc >= width_eff) begin
          column_index <= '0;
          in_first_row <= 1'b0;
        end else begin
          column_index <= col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl.cur       <= pixel.pixel_black;
      s1_ctrl.last      <= pixel.last_pixel;
      s1_ctrl.window_en <= !in_first_row && (col != '0);
      s1_ctrl.first_row <= in_first_row;
    end
  end

  enr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LINE)
  ) u_row_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (pixel.pixel_black),
    .re    (accept),
    .raddr (col),
    .rdata (upper_raw)
  );

  enr_quad_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .ctrl         (s1_ctrl),
    .upper_raw    (upper_raw),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

// ----- bench/blob_euler_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// blob_euler_tracker_pkg
// Bit-quad counting of a pixel stream and the queue of blob results it owes.
// Follows the accepted pixels with its own line buffer, window position and
// six saturating class counters, works out the counts and the Euler number of
// each blob when its last pixel is taken, and compares the block's result
// transactions against them in order.
// ----------------------------------------------------------------------------
package blob_euler_tracker_pkg;
  import enr_pkg::*;

  localparam int unsigned LINE_DEPTH = 256;
  localparam int unsigned COUNT_MAX  = 65535;

  class blob_euler_tracker;
    logic [WIDTH_REG_BITS-1:0] line_width;
    bit                        row_above [LINE_DEPTH];
    bit                        left_px;
    bit                        upper_left_px;
    bit                        first_row;
    int unsigned               col;
    int unsigned               quad_count [NUM_CLASSES];
    result_t                   blob_results_due [$];
    int unsigned               errors;

    function new();
      line_width = WIDTH_RESET;
      errors = 0;
      clear_blob();
    endfunction

    function void clear_blob();
      left_px = 1'b0;
      upper_left_px = 1'b0;
      col = 0;
      first_row = 1'b1;
      foreach (quad_count[k]) quad_count[k] = 0;
    endfunction

    function int unsigned active_width();
      if (line_width < WIDTH_MIN) return WIDTH_MIN;
      if (line_width > LINE_DEPTH) return LINE_DEPTH;
      return line_width;
    endfunction

    function int unsigned pending();
      return blob_results_due.size();
    endfunction

    // a b on top, c d below
    function quad_class_t quad_of(bit a, bit b, bit c, bit d);
      int unsigned n;
      n = int'(a) + int'(b) + int'(c) + int'(d);
      case (n)
        0: return QUAD_EMPTY;
        1: return QUAD_ONE;
        2: begin
          if ((a && d) || (b && c)) return QUAD_DIAGONAL;
          return QUAD_TWO_ADJ;
        end
        3: return QUAD_THREE;
        default: return QUAD_FULL;
      endcase
    endfunction

    function void take_pixel(pixel_in_t px);
      int unsigned w;
      bit          upper;
      quad_class_t cls;
      result_t     due;
      int          num;
      int          eul;
      w = active_width();
      if (col >= w) col = 0;
      upper = first_row ? 1'b0 : row_above[col];
      if (!first_row && col > 0) begin
        cls = quad_of(upper_left_px, upper, left_px, px.pixel_black);
        if (quad_count[cls] < COUNT_MAX) quad_count[cls]++;
      end
      upper_left_px = upper;
      left_px = px.pixel_black;
      row_above[col] = px.pixel_black;
      if (col + 1 >= w) begin
        col = 0;
        first_row = 1'b0;
        left_px = 1'b0;
        upper_left_px = 1'b0;
      end else begin
        col++;
      end
      if (px.last_pixel) begin
        num = int'(quad_count[QUAD_ONE]) - int'(quad_count[QUAD_THREE])
              - 2 * int'(quad_count[QUAD_DIAGONAL]);
        eul = num / 4;
        if (eul > 32767) eul = 32767;
        if (eul < -32768) eul = -32768;
        due.count_empty        = quad_count[QUAD_EMPTY][RESULT_BITS-1:0];
        due.count_one          = quad_count[QUAD_ONE][RESULT_BITS-1:0];
        due.count_two_adjacent = quad_count[QUAD_TWO_ADJ][RESULT_BITS-1:0];
        due.count_three        = quad_count[QUAD_THREE][RESULT_BITS-1:0];
        due.count_full         = quad_count[QUAD_FULL][RESULT_BITS-1:0];
        due.count_diagonal     = quad_count[QUAD_DIAGONAL][RESULT_BITS-1:0];
        due.euler_number       = eul[RESULT_BITS-1:0];
        blob_results_due.push_back(due);
        clear_blob();
      end
    endfunction

    function void check_field(string name, logic [RESULT_BITS-1:0] want_v,
                              logic [RESULT_BITS-1:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %h, got %h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t due;
      if (blob_results_due.size() == 0) begin
        $error("result transaction with no blob result due: %h", got);
        errors++;
        return;
      end
      due = blob_results_due.pop_front();
      check_field("count_empty", due.count_empty, got.count_empty);
      check_field("count_one", due.count_one, got.count_one);
      check_field("count_two_adjacent", due.count_two_adjacent, got.count_two_adjacent);
      check_field("count_three", due.count_three, got.count_three);
      check_field("count_full", due.count_full, got.count_full);
      check_field("count_diagonal", due.count_diagonal, got.count_diagonal);
      check_field("euler_number", due.euler_number, got.euler_number);
    endfunction
  endclass

endpackage

// ----- bench/tb_euler_number_bit_quads_core.sv -----
// ----------------------------------------------------------------------------
// tb_euler_number_bit_quads_core
// Streams padded binary blobs through the bit-quad Euler number core.
// Directed 2x2 class patterns and width extremes come first, then random
// framed and unframed blobs with early ends and width changes between blobs,
// under three sender/receiver idle mixes, and finally a grid blob and a
// checkerboard blob.
// ----------------------------------------------------------------------------
module tb_euler_number_bit_quads_core;
  timeunit 1ns;
  timeprecision 1ps;

  import enr_pkg::*;
  import blob_euler_tracker_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NO_STOP        = 32'hFFFF_FFFF;

  typedef enum {BOX_RANDOM, BOX_FRAMED, BOX_GRID, BOX_CHECKER} box_pattern_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_en = 1'b0;
  logic [WIDTH_REG_BITS-1:0] cfg_write_data = '0;
  logic                      pixel_valid = 1'b0;
  logic                      pixel_stall;
  pixel_in_t                 pixel = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_t                   result;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned quiet_cycles = 0;

  blob_euler_tracker blob_tracker = new();

  euler_number_bit_quads_core #(
    .MAX_LINE  (LINE_DEPTH),
    .COUNT_BITS(16)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel         (pixel),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) blob_tracker.match_result(result);
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_euler_number_bit_quads_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input bit black, input bit last);
    pixel_in_t px;
    px.pixel_black = black;
    px.last_pixel = last;
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= px;
    do @(posedge clk); while (pixel_stall);
    blob_tracker.take_pixel(px);
    pixels_sent++;
  endtask

  // only between blobs, once all results are in
  task automatic write_line_width(input logic [WIDTH_REG_BITS-1:0] value);
    pixel_valid <= 1'b0;
    while (blob_tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    blob_tracker.line_width = value;
  endtask

  function automatic bit pixel_at(input box_pattern_t pat, input int unsigned r,
                                  input int unsigned c, input int unsigned rows,
                                  input int unsigned w, input int unsigned density);
    case (pat)
      BOX_FRAMED:
        return (r > 0 && c > 0 && r + 1 < rows && c + 1 < w) &&
               ($urandom_range(99) < density);
      BOX_GRID:    return (r % 2 == 0) && (c % 2 == 0);
      BOX_CHECKER: return (r + 3 >= rows) || ((r + c) % 2 == 1);
      default:     return $urandom_range(99) < density;
    endcase
  endfunction

  task automatic send_box(input box_pattern_t pat, input int unsigned rows,
                          input int unsigned density, input int unsigned stop_at);
    int unsigned w;
    int unsigned last_idx;
    int unsigned idx;
    w = blob_tracker.active_width();
    last_idx = (stop_at < rows * w) ? stop_at : rows * w - 1;
    for (idx = 0; idx <= last_idx; idx++) begin
      send_pixel(pixel_at(pat, idx / w, idx % w, rows, w, density), idx == last_idx);
    end
  endtask

  task automatic send_bits(input bit [7:0] bits, input int count);
    int i;
    for (i = count - 1; i >= 0; i--) send_pixel(bits[i], i == 0);
  endtask

  task automatic run_random(input int unsigned item_goal);
    int unsigned goal_end;
    int unsigned pick;
    int unsigned rows;
    int unsigned w;
    goal_end = pixels_sent + item_goal;
    while (pixels_sent < goal_end) begin
      if ($urandom_range(3) == 0 || blob_tracker.active_width() > 64) begin
        pick = $urandom_range(99);
        if (pick < 5) write_line_width($urandom_range(1));
        else if (pick < 10) write_line_width($urandom_range(511, 257));
        else if (pick < 15) write_line_width($urandom_range(64, 13));
        else write_line_width($urandom_range(12, 2));
      end
      w = blob_tracker.active_width();
      rows = (w > 64) ? $urandom_range(2, 1) : $urandom_range(6, 1);
      pick = $urandom_range(99);
      if (pick < 70) send_box(BOX_FRAMED, rows, $urandom_range(90, 10), NO_STOP);
      else if (pick < 90) send_box(BOX_RANDOM, rows, $urandom_range(100), NO_STOP);
      else send_box(BOX_RANDOM, rows, 50, $urandom_range(rows * w - 1));
    end
  endtask

  initial begin
    send_idle_pct = 36;
    recv_stall_pct = 49;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // width clamps to two; each box gives two or one windows of chosen classes
    write_line_width(9'd0);
    send_bits(8'b00_00_10, 6);
    send_bits(8'b10_10_11, 6);
    send_bits(8'b10_01_10, 6);
    send_bits(8'b11_11, 4);
    // width clamps to the line depth; blob ends in mid first row
    write_line_width(9'd511);
    send_bits(8'b101, 3);

    run_random(330);
    send_idle_pct = 49;
    recv_stall_pct = 36;
    run_random(330);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(340);

    // grid and checkerboard blobs
    write_line_width(9'd8);
    send_box(BOX_GRID, 6, 0, NO_STOP);
    send_box(BOX_CHECKER, 6, 0, NO_STOP);

    pixel_valid <= 1'b0;
    while (blob_tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (blob_tracker.errors == 0 && blob_tracker.pending() == 0) begin
      $display("tb_euler_number_bit_quads_core: done, clean");
    end else begin
      $display("tb_euler_number_bit_quads_core: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/enr_pkg.sv
design/enr_ram.sv
design/enr_quad_accum.sv
design/euler_number_bit_quads_core.sv
bench/blob_euler_tracker_pkg.sv
bench/tb_euler_number_bit_quads_core.sv
